>>> src/quadtree_bitstream_decoder_core_assert.svh
// Assertion macros shared by the quadtree decoder RTL.
// Needs nothing else; the including module supplies clock and reset names.
`ifndef QUADTREE_BITSTREAM_DECODER_CORE_ASSERT_SVH
`define QUADTREE_BITSTREAM_DECODER_CORE_ASSERT_SVH
// Consequent must hold in the same cycle as the antecedent.
`define QTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define QTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> src/qtd_pkg.sv
// Shared constants, types and helper functions of the quadtree decoder.
// Depends on nothing; used by qtd_ctrl, qtd_dp and the top level.
package qtd_pkg;
	localparam int MAX_LEVELS  = 6;
	localparam int IDX_W       = 2 * MAX_LEVELS + 1;
	localparam int STORE_DEPTH = ((1 << (2 * (MAX_LEVELS + 1))) - 1) / 3;
	localparam int LVL_W       = 3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_PENDING = 2'd3;

	typedef enum logic [1:0] {
		KIND_MEAN    = 2'd0,
		KIND_ERROR   = 2'd1,
		KIND_UNIFORM = 2'd2
	} qtd_kind_t;

	typedef struct packed {
		logic capture;
		logic dispatch;
		logic par_read;
		logic set_apply;
		logic bit_step;
		logic resp_load;
	} qtd_cmd_t;

	typedef struct packed {
		logic opcode;
		logic tree_done;
		logic read_ok;
		logic settle_go;
		logic set_chain;
		logic bits_zero;
	} qtd_sts_t;

	// Node count of a tree with h+1 levels: ones at every even bit up to 2h.
	function automatic logic [IDX_W-1:0] nodes_up_to(input logic [LVL_W-1:0] h);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int k = 0; k <= MAX_LEVELS; k++) begin
			if (k <= int'(h)) r[2*k] = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [LVL_W-1:0] clamp_levels(input logic [LVL_W-1:0] v);
		logic [LVL_W-1:0] r;
		r = v;
		if (v == '0) r = LVL_W'(1);
		else if (int'(v) > MAX_LEVELS) r = LVL_W'(MAX_LEVELS);
		return r;
	endfunction
endpackage

>>> src/qtd_dp.sv
// Datapath of the quadtree decoder: node memory, bit reader, field decoder, output register.
// Depends on qtd_pkg; driven by qtd_ctrl through qtd_cmd_t.
module qtd_dp import qtd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qtd_cmd_t             cmd,
	output qtd_sts_t             sts,
	input  logic                 cfg_write,
	input  logic [LVL_W-1:0]     cfg_data,
	input  logic                 opcode,
	input  logic [7:0]           stream_byte,
	input  logic [IDX_W-1:0]     node_index,
	output logic [1:0]           status,
	output logic                 tree_done,
	output logic [IDX_W-1:0]     nodes_decoded,
	output logic [7:0]           mean_value,
	output logic [1:0]           error_value,
	output logic                 uniform_flag
);
	logic [10:0]      mem [0:STORE_DEPTH-1];
	logic [10:0]      rd_q;
	logic [IDX_W-1:0] next_q, total_q, inner_q, idx_q;
	logic [7:0]       byte_q, acc_q, sum_q, cur_m_q;
	logic [3:0]       bits_left_q, need_q;
	qtd_kind_t        kind_q;
	logic             op_q;
	logic [1:0]       stat_q;

	logic             done, read_ok, inherit, leaf, in_bit, fin;
	logic [7:0]       par_m, m4, acc_nx, m_fin;
	logic [1:0]       par_e;
	logic [3:0]       need_nx;
	logic             we, re, m_set, adv;
	logic [IDX_W-1:0] ra;
	logic [10:0]      wd;

	assign done    = (next_q >= total_q);
	assign read_ok = (idx_q < total_q) && (idx_q < next_q);
	assign par_m   = rd_q[10:3];
	assign par_e   = rd_q[2:1];
	assign inherit = rd_q[0] && (par_e == 2'd0);
	assign leaf    = (next_q >= inner_q);
	assign m4      = {par_m[5:0], 2'b00} + {6'd0, par_e} - sum_q;
	assign in_bit  = byte_q[3'(bits_left_q - 4'd1)];
	assign acc_nx  = {acc_q[6:0], in_bit};
	assign need_nx = need_q - 4'd1;
	assign fin     = cmd.bit_step && (need_nx == 4'd0);

	assign sts.opcode    = op_q;
	assign sts.tree_done = done;
	assign sts.read_ok   = read_ok;
	assign sts.settle_go = !done && (kind_q == KIND_MEAN) && (next_q != '0);
	assign sts.set_chain = inherit || (next_q[1:0] == 2'b00);
	assign sts.bits_zero = (bits_left_q == 4'd0);

	assign re = cmd.par_read || (cmd.dispatch && op_q && read_ok);
	assign ra = cmd.par_read ? IDX_W'((next_q - IDX_W'(1)) >> 2) : idx_q;

	// Node write, the finalized mean (for the sibling sum) and node advance.
	always_comb begin
		we    = 1'b0;
		wd    = '0;
		m_set = 1'b0;
		m_fin = '0;
		adv   = 1'b0;
		if (cmd.set_apply) begin
			if (inherit) begin
				we = 1'b1; wd = {par_m, 2'b00, 1'b1}; m_set = 1'b1; m_fin = par_m; adv = 1'b1;
			end else if (next_q[1:0] == 2'b00) begin
				we = 1'b1; wd = {m4, 2'b00, leaf}; m_set = 1'b1; m_fin = m4; adv = leaf;
			end
		end else if (fin) begin
			we = 1'b1;
			case (kind_q)
				KIND_MEAN: begin
					wd = {acc_nx, 2'b00, leaf}; m_set = 1'b1; m_fin = acc_nx; adv = leaf;
				end
				KIND_ERROR: begin
					wd  = {cur_m_q, acc_nx[1:0], 1'b0};
					adv = (acc_nx[1:0] != 2'd0);
				end
				default: begin
					wd  = {cur_m_q, 2'b00, acc_nx[0]};
					adv = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[next_q] <= wd;
		if (re) rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= nodes_up_to(clamp_levels(LVL_W'(6)));
			inner_q     <= nodes_up_to(clamp_levels(LVL_W'(6)) - LVL_W'(1));
			next_q      <= '0;
			bits_left_q <= '0;
			acc_q       <= '0;
			need_q      <= 4'd8;
			kind_q      <= KIND_MEAN;
		end else if (cfg_write) begin
			total_q     <= nodes_up_to(clamp_levels(cfg_data));
			inner_q     <= nodes_up_to(clamp_levels(cfg_data) - LVL_W'(1));
			next_q      <= '0;
			bits_left_q <= '0;
			acc_q       <= '0;
			need_q      <= 4'd8;
			kind_q      <= KIND_MEAN;
		end else begin
			if (adv) next_q <= next_q + IDX_W'(1);
			if (cmd.dispatch && !op_q && !done) bits_left_q <= 4'd8;
			if (cmd.resp_load) bits_left_q <= '0;
			if (cmd.set_apply && !inherit && (next_q[1:0] == 2'b00) && !leaf) begin
				kind_q <= KIND_ERROR;
				need_q <= 4'd2;
				acc_q  <= '0;
			end
			if (cmd.bit_step) begin
				bits_left_q <= bits_left_q - 4'd1;
				if (!fin) begin
					acc_q  <= acc_nx;
					need_q <= need_nx;
				end else begin
					acc_q <= '0;
					case (kind_q)
						KIND_MEAN: begin
							if (leaf) begin
								need_q <= 4'd8;
							end else begin
								kind_q <= KIND_ERROR;
								need_q <= 4'd2;
							end
						end
						KIND_ERROR: begin
							if (acc_nx[1:0] != 2'd0) begin
								kind_q <= KIND_MEAN;
								need_q <= 4'd8;
							end else begin
								kind_q <= KIND_UNIFORM;
								need_q <= 4'd1;
							end
						end
						default: begin
							kind_q <= KIND_MEAN;
							need_q <= 4'd8;
						end
					endcase
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (m_set) begin
			cur_m_q <= m_fin;
			sum_q   <= (next_q[1:0] == 2'b01) ? m_fin : sum_q + m_fin;
		end
		if (cmd.capture) begin
			op_q   <= opcode;
			byte_q <= stream_byte;
			idx_q  <= node_index;
		end
		if (cmd.dispatch) begin
			if (!op_q) stat_q <= done ? ST_IGNORED : ST_OK;
			else if (idx_q >= total_q) stat_q <= ST_RANGE;
			else if (idx_q >= next_q) stat_q <= ST_PENDING;
			else stat_q <= ST_OK;
		end
		if (cmd.resp_load) begin
			status        <= stat_q;
			tree_done     <= done;
			nodes_decoded <= next_q;
			if (op_q && (stat_q == ST_OK)) begin
				mean_value   <= rd_q[10:3];
				error_value  <= rd_q[2:1];
				uniform_flag <= rd_q[0];
			end else begin
				mean_value   <= '0;
				error_value  <= '0;
				uniform_flag <= 1'b0;
			end
		end
	end
endmodule

>>> src/qtd_ctrl.sv
// Sequencing state machine of the quadtree decoder and the handshakes of all channels.
// Depends on qtd_pkg and quadtree_bitstream_decoder_core_assert.svh.
`include "quadtree_bitstream_decoder_core_assert.svh"
module qtd_ctrl import qtd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output logic     cfg_ready,
	output qtd_cmd_t cmd,
	input  qtd_sts_t sts
);
	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_SETTLE, S_APPLY, S_BIT, S_RD_WAIT, S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.dispatch  = (state_q == S_DISPATCH);
		cmd.par_read  = (state_q == S_SETTLE) && sts.settle_go;
		cmd.set_apply = (state_q == S_APPLY);
		cmd.bit_step  = (state_q == S_BIT) && !sts.tree_done && !sts.bits_zero;
		cmd.resp_load = (state_q == S_RESP) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					if (sts.opcode) state_q <= sts.read_ok ? S_RD_WAIT : S_RESP;
					else state_q <= sts.tree_done ? S_RESP : S_SETTLE;
				end
				S_SETTLE: begin
					state_q <= sts.settle_go ? S_APPLY : S_BIT;
				end
				S_APPLY: begin
					state_q <= sts.set_chain ? S_SETTLE : S_BIT;
				end
				S_BIT: begin
					state_q <= (sts.tree_done || sts.bits_zero) ? S_RESP : S_SETTLE;
				end
				S_RD_WAIT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`QTD_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, in_valid && in_ready, state_q == S_DISPATCH, "accepted transaction was not dispatched")
	`QTD_ASSERT_NOW(a_bit_pending, clk, arst_n, cmd.bit_step, !sts.tree_done && !sts.bits_zero, "bit consumed with none pending")
	`QTD_ASSERT_NEXT(a_resp_shown, clk, arst_n, cmd.resp_load, out_valid_q && (state_q == S_IDLE), "result not presented")
	`QTD_ASSERT_NOW(a_single_cmd, clk, arst_n, 1'b1, $onehot0({cmd.dispatch, cmd.par_read, cmd.set_apply, cmd.bit_step, cmd.resp_load}), "conflicting datapath commands")
endmodule

>>> src/quadtree_bitstream_decoder_core.sv
// Sequence: a read of a decoded node passes the dispatch, read-wait and result states; another
// read or an ignored byte goes from dispatch to result. A byte takes a settle and a bit step per
// bit (with an apply step between when the parent is fetched from the node memory), plus a settle
// and an apply per inherited node. Throughput: one transaction at a time.
// The result register frees the input side while a result waits to be taken.
// Reset (asynchronous, active low) sets levels to 6 and restarts at the root; memory kept.
module quadtree_bitstream_decoder_core import qtd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             opcode,
	input  logic [7:0]       stream_byte,
	input  logic [IDX_W-1:0] node_index,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic             tree_done,
	output logic [IDX_W-1:0] nodes_decoded,
	output logic [7:0]       mean_value,
	output logic [1:0]       error_value,
	output logic             uniform_flag,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LVL_W-1:0] cfg_data
);
	qtd_cmd_t cmd;
	qtd_sts_t sts;

	qtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	qtd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.stream_byte   (stream_byte),
		.node_index    (node_index),
		.status        (status),
		.tree_done     (tree_done),
		.nodes_decoded (nodes_decoded),
		.mean_value    (mean_value),
		.error_value   (error_value),
		.uniform_flag  (uniform_flag)
	);
endmodule

>>> tb/quadtree_bitstream_decoder_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for quadtree_bitstream_decoder_core: random byte streams and node reads
// against a behavioral quadtree decoder in a scoreboard class. Depends on qtd_pkg and the core.
module quadtree_bitstream_decoder_core_tb;
	import qtd_pkg::*;

	typedef struct {
		logic [1:0]       status;
		logic             tree_done;
		logic [IDX_W-1:0] nodes_decoded;
		logic [7:0]       mean_value;
		logic [1:0]       error_value;
		logic             uniform_flag;
	} node_reply_t;

	class decoder_scoreboard;
		logic [7:0] mean_mem [STORE_DEPTH];
		logic [1:0] err_mem [STORE_DEPTH];
		logic       uni_mem [STORE_DEPTH];
		int         height;
		int         next_idx;
		int         acc;
		int         need;
		qtd_kind_t  kind;
		node_reply_t replies_due[$];
		int         errors;

		function new();
			height = MAX_LEVELS;
			errors = 0;
			restart();
		endfunction

		function void restart();
			next_idx = 0;
			acc = 0;
			need = 8;
			kind = KIND_MEAN;
		endfunction

		function int tree_size(int h);
			return ((1 << (2 * (h + 1))) - 1) / 3;
		endfunction

		function void set_levels(logic [LVL_W-1:0] v);
			height = (v == 0) ? 1 : ((int'(v) > MAX_LEVELS) ? MAX_LEVELS : int'(v));
			restart();
		endfunction

		// Resolves nodes at the head of the order that take no bits from the stream.
		function void settle_free_nodes();
			int total;
			int inner;
			int p;
			int m;
			total = tree_size(height);
			inner = tree_size(height - 1);
			while (next_idx < total && kind == KIND_MEAN) begin
				if (next_idx == 0) return;
				p = (next_idx - 1) >> 2;
				if (uni_mem[p] == 1'b1 && err_mem[p] == 2'd0) begin
					mean_mem[next_idx] = mean_mem[p];
					err_mem[next_idx] = 2'd0;
					uni_mem[next_idx] = 1'b1;
					next_idx++;
					continue;
				end
				if ((next_idx & 3) != 0) return;
				m = (4 * mean_mem[p] + err_mem[p] - (mean_mem[next_idx-3]
					+ mean_mem[next_idx-2] + mean_mem[next_idx-1])) & 255;
				mean_mem[next_idx] = m[7:0];
				err_mem[next_idx] = 2'd0;
				if (next_idx >= inner) begin
					uni_mem[next_idx] = 1'b1;
					next_idx++;
				end else begin
					uni_mem[next_idx] = 1'b0;
					kind = KIND_ERROR;
					need = 2;
					acc = 0;
				end
			end
		endfunction

		function void close_field();
			int v;
			v = acc;
			acc = 0;
			case (kind)
				KIND_MEAN: begin
					mean_mem[next_idx] = v[7:0];
					err_mem[next_idx] = 2'd0;
					if (next_idx >= tree_size(height - 1)) begin
						uni_mem[next_idx] = 1'b1;
						next_idx++;
						need = 8;
					end else begin
						uni_mem[next_idx] = 1'b0;
						kind = KIND_ERROR;
						need = 2;
					end
				end
				KIND_ERROR: begin
					err_mem[next_idx] = v[1:0];
					uni_mem[next_idx] = 1'b0;
					if (v != 0) begin
						next_idx++;
						kind = KIND_MEAN;
						need = 8;
					end else begin
						kind = KIND_UNIFORM;
						need = 1;
					end
				end
				default: begin
					err_mem[next_idx] = 2'd0;
					uni_mem[next_idx] = v[0];
					next_idx++;
					kind = KIND_MEAN;
					need = 8;
				end
			endcase
		endfunction

		function void note_input(logic op, logic [7:0] b, logic [IDX_W-1:0] idx);
			node_reply_t r;
			int total;
			total = tree_size(height);
			r.status = ST_OK;
			r.mean_value = '0;
			r.error_value = '0;
			r.uniform_flag = 1'b0;
			if (op == 1'b0) begin
				if (next_idx >= total) r.status = ST_IGNORED;
				else begin
					for (int k = 7; k >= 0; k--) begin
						settle_free_nodes();
						if (next_idx >= total) break;
						acc = ((acc << 1) | b[k]) & 255;
						need--;
						if (need == 0) close_field();
					end
					settle_free_nodes();
				end
			end else if (int'(idx) >= total) r.status = ST_RANGE;
			else if (int'(idx) >= next_idx) r.status = ST_PENDING;
			else begin
				r.mean_value = mean_mem[idx];
				r.error_value = err_mem[idx];
				r.uniform_flag = uni_mem[idx];
			end
			r.tree_done = (next_idx >= total);
			r.nodes_decoded = next_idx[IDX_W-1:0];
			replies_due.push_back(r);
		endfunction

		function void check_reply(node_reply_t a);
			node_reply_t e;
			if (replies_due.size() == 0) begin
				$display("%0t: result with no transaction pending", $time);
				errors++;
				return;
			end
			e = replies_due.pop_front();
			if (a.status !== e.status) begin
				$display("%0t: status exp %0d act %0d", $time, e.status, a.status);
				errors++;
			end
			if (a.tree_done !== e.tree_done) begin
				$display("%0t: tree_done exp %0d act %0d", $time, e.tree_done, a.tree_done);
				errors++;
			end
			if (a.nodes_decoded !== e.nodes_decoded) begin
				$display("%0t: nodes_decoded exp %0d act %0d", $time,
					e.nodes_decoded, a.nodes_decoded);
				errors++;
			end
			if (a.mean_value !== e.mean_value) begin
				$display("%0t: mean_value exp %0d act %0d", $time, e.mean_value, a.mean_value);
				errors++;
			end
			if (a.error_value !== e.error_value) begin
				$display("%0t: error_value exp %0d act %0d", $time,
					e.error_value, a.error_value);
				errors++;
			end
			if (a.uniform_flag !== e.uniform_flag) begin
				$display("%0t: uniform_flag exp %0d act %0d", $time,
					e.uniform_flag, a.uniform_flag);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic             opcode;
	logic [7:0]       stream_byte;
	logic [IDX_W-1:0] node_index;
	logic             out_valid;
	logic             out_ready;
	logic [1:0]       status;
	logic             tree_done;
	logic [IDX_W-1:0] nodes_decoded;
	logic [7:0]       mean_value;
	logic [1:0]       error_value;
	logic             uniform_flag;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LVL_W-1:0] cfg_data;

	decoder_scoreboard sb;
	bit calm;
	int sent;

	quadtree_bitstream_decoder_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .stream_byte(stream_byte), .node_index(node_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .tree_done(tree_done), .nodes_decoded(nodes_decoded),
		.mean_value(mean_value), .error_value(error_value), .uniform_flag(uniform_flag),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic send_item(logic op, logic [7:0] b, logic [IDX_W-1:0] idx);
		in_valid <= 1'b1;
		opcode <= op;
		stream_byte <= b;
		node_index <= idx;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op, b, idx);
		sent++;
		if (!calm && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// Registers change only with the pipeline drained.
	task automatic write_levels(logic [LVL_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_levels(v);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h24;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_item();
		int total;
		total = sb.tree_size(sb.height);
		if ($urandom_range(0, 99) < 65) send_item(1'b0, pick_byte(), IDX_W'($urandom));
		else if ($urandom_range(0, 9) == 0)
			send_item(1'b1, 8'($urandom), IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
		else send_item(1'b1, 8'($urandom), IDX_W'($urandom_range(0, total + 3)));
	endtask

	// Result side: random stall bursts until the calm tail of the run.
	initial begin
		node_reply_t a;
		int stall;
		stall = 0;
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				a.status = status;
				a.tree_done = tree_done;
				a.nodes_decoded = nodes_decoded;
				a.mean_value = mean_value;
				a.error_value = error_value;
				a.uniform_flag = uniform_flag;
				sb.check_reply(a);
			end
			if (stall > 0) stall--;
			else if (!calm && $urandom_range(0, 99) < 10) stall = $urandom_range(1, 15);
			out_ready <= (stall == 0);
		end
	end

	initial begin
		#20ms;
		$display("FAIL quadtree_bitstream_decoder_core");
		$finish;
	end

	initial begin
		logic [LVL_W-1:0] lv_list [6];
		sb = new();
		calm = 0;
		sent = 0;
		lv_list = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd6};
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 1'b0;
		stream_byte = '0;
		node_index = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset height: pending and out-of-range reads, then a uniform root.
		send_item(1'b1, 8'h00, IDX_W'(0));
		send_item(1'b1, 8'hFF, IDX_W'((1 << IDX_W) - 1));
		send_item(1'b1, 8'h00, IDX_W'(5460));
		send_item(1'b0, 8'hA5, '0);
		send_item(1'b0, 8'h20, '0);
		send_item(1'b1, 8'h00, IDX_W'(5460));
		send_item(1'b0, 8'h00, '0);
		send_item(1'b1, 8'h00, IDX_W'(1365));

		// Level write of zero clamps to one: five nodes, bytes after completion ignored.
		write_levels(3'd0);
		send_item(1'b0, 8'hFF, '0);
		send_item(1'b0, 8'hC0, '0);
		send_item(1'b0, 8'h00, '0);
		send_item(1'b0, 8'h7F, '0);
		send_item(1'b0, 8'hFF, '0);
		send_item(1'b0, 8'h80, '0);
		for (int i = 0; i < 6; i++) send_item(1'b1, 8'h00, IDX_W'(i));
		write_levels(3'd7);
		send_item(1'b1, 8'h00, IDX_W'(0));
		send_item(1'b0, 8'h5A, '0);

		while (sent < 1950) begin
			write_levels(($urandom_range(0, 3) == 0) ? LVL_W'($urandom)
				: lv_list[$urandom_range(0, 5)]);
			repeat ($urandom_range(40, 150)) begin
				if (sent > 1700) calm = 1;
				random_item();
			end
		end

		in_valid <= 1'b0;
		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0) $display("PASS quadtree_bitstream_decoder_core");
		else $display("FAIL quadtree_bitstream_decoder_core");
		$finish;
	end
endmodule
